// File: hdl/level_frame_deframer_core_defines.svh
// Assertion macros for the level frame deframer.
// Included by the top level; depends on i_clk and i_rst_n in the including scope.
`ifndef LEVEL_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define LEVEL_FRAME_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LFD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfd: same-cycle check failed");
// next-cycle implication
`define LFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfd: next-cycle check failed");
`else
`define LFD_ASSERT_IMPLY(label, ante, cons)
`define LFD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/lfd_pkg.sv
// Shared types and constants of the level frame deframer.
// No dependencies; used by lfd_front, lfd_back and the top level.
package lfd_pkg;

    // Frame format constants
    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] VERB_LEVELS = 8'h01;
    localparam logic [7:0] LEN_MIN     = 8'd1;
    localparam logic [7:0] LEN_MAX     = 8'd127;
    localparam int         CAPTURE_BYTES = 17;

    // Register indexes of the configuration port
    typedef enum logic {
        REG_SOURCE_ID = 1'b0
    } t_reg_idx;

    // Received byte with its classification flags
    typedef struct packed {
        logic [7:0] data;
        logic       is_sync;
        logic       len_ok;
        logic       verb_ok;
    } t_item;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // Back end status
    typedef struct packed {
        logic pop;
        logic emit;
    } t_back_stat;

    // Deframer phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_VERB   = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CHECK  = 5'b10000
    } t_phase;

endpackage

// File: hdl/lfd_front.sv
// Front end: accepts received bytes, classifies them and queues them.
// Depends on lfd_pkg.
module lfd_front #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_rx_byte,
    output lfd_pkg::t_qhead o_head,
    input  logic           i_pop,
    output logic           o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfd_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    lfd_pkg::t_item   cls_item;
    logic             push;

    // Classify the incoming byte
    always_comb begin
        cls_item.data    = i_rx_byte;
        cls_item.is_sync = (i_rx_byte == lfd_pkg::SYNC_BYTE);
        cls_item.len_ok  = i_rx_byte inside {[lfd_pkg::LEN_MIN:lfd_pkg::LEN_MAX]};
        cls_item.verb_ok = (i_rx_byte == lfd_pkg::VERB_LEVELS);
    end

    assign o_stall = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push    = i_valid && !o_stall;

    assign o_head.valid = !o_empty;
    assign o_head.item  = r_mem[r_rd_ptr];

    // Pointer and fill-count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls_item;
        end
    end

endmodule

// File: hdl/lfd_back.sv
// Back end: frame state machine, payload capture, checksum and record register.
// Depends on lfd_pkg; fed from lfd_front's queue head.
module lfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfd_pkg::t_qhead    i_head,
    input  logic [7:0]         i_source_id,
    output lfd_pkg::t_back_stat o_stat,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_source_tag,
    output logic [7:0]         o_channel,
    output logic [31:0]        o_level_a,
    output logic [31:0]        o_level_b,
    output logic [31:0]        o_level_c,
    output logic [31:0]        o_level_d,
    output logic [7:0]         o_tail_byte
);

    localparam int NCAP = lfd_pkg::CAPTURE_BYTES;

    lfd_pkg::t_phase r_phase, n_phase;
    logic [6:0] r_frame_len, n_frame_len;
    logic [6:0] r_bytes_read, n_bytes_read;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_cap [NCAP];
    logic       cap_we;
    logic [6:0] cap_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_src_tag, r_channel, r_tail;
    logic [31:0] r_level_a, r_level_b, r_level_c, r_level_d;
    logic       ready, pop, emit;
    logic [7:0] data;

    assign data  = i_head.item.data;
    assign ready = !r_out_valid || !i_stall;
    assign pop   = i_head.valid && ready;

    // Frame state machine
    always_comb begin
        n_phase      = r_phase;
        n_frame_len  = r_frame_len;
        n_bytes_read = r_bytes_read;
        n_sum        = r_sum;
        cap_we       = 1'b0;
        cap_idx      = r_bytes_read - 7'd1;
        emit         = 1'b0;
        if (pop) begin
            case (r_phase)
                lfd_pkg::PH_HUNT: begin
                    if (i_head.item.is_sync) begin
                        n_phase = lfd_pkg::PH_LENGTH;
                    end
                end
                lfd_pkg::PH_LENGTH: begin
                    if (i_head.item.len_ok) begin
                        n_frame_len  = data[6:0];
                        n_bytes_read = 7'd0;
                        n_phase      = lfd_pkg::PH_VERB;
                    end else begin
                        n_phase      = lfd_pkg::PH_HUNT;
                        n_frame_len  = 7'd0;
                        n_bytes_read = 7'd0;
                    end
                end
                lfd_pkg::PH_VERB: begin
                    if (i_head.item.verb_ok) begin
                        n_sum        = data;
                        n_bytes_read = 7'd1;
                        n_phase      = (r_frame_len == 7'd1) ? lfd_pkg::PH_CHECK
                                                             : lfd_pkg::PH_DATA;
                    end else begin
                        n_phase      = lfd_pkg::PH_HUNT;
                        n_frame_len  = 7'd0;
                        n_bytes_read = 7'd0;
                    end
                end
                lfd_pkg::PH_DATA: begin
                    cap_we       = (cap_idx < 7'(NCAP));
                    n_sum        = r_sum + data;
                    n_bytes_read = r_bytes_read + 7'd1;
                    if (n_bytes_read == r_frame_len) begin
                        n_phase = lfd_pkg::PH_CHECK;
                    end
                end
                lfd_pkg::PH_CHECK: begin
                    emit         = (r_sum == data) && (r_frame_len >= 7'(NCAP + 1));
                    n_phase      = lfd_pkg::PH_HUNT;
                    n_frame_len  = 7'd0;
                    n_bytes_read = 7'd0;
                end
                default: begin
                    n_phase      = lfd_pkg::PH_HUNT;
                    n_frame_len  = 7'd0;
                    n_bytes_read = 7'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lfd_pkg::PH_HUNT;
            r_frame_len  <= 7'd0;
            r_bytes_read <= 7'd0;
            r_sum        <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_frame_len  <= n_frame_len;
            r_bytes_read <= n_bytes_read;
            r_sum        <= n_sum;
        end
    end

    // Payload capture, first bytes of the frame only
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NCAP; k++) begin
            if (cap_we && (cap_idx == 7'(k))) begin
                r_cap[k] <= data;
            end
        end
    end

    // Record register: holds until taken, reloads on emit
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_src_tag <= i_source_id;
            r_channel <= r_cap[0];
            r_level_a <= {r_cap[1], r_cap[2], r_cap[3], r_cap[4]};
            r_level_b <= {r_cap[5], r_cap[6], r_cap[7], r_cap[8]};
            r_level_c <= {r_cap[9], r_cap[10], r_cap[11], r_cap[12]};
            r_level_d <= {r_cap[13], r_cap[14], r_cap[15], r_cap[16]};
            r_tail    <= r_cap[16];
        end
    end

    assign o_stat.pop   = pop;
    assign o_stat.emit  = emit;
    assign o_valid      = r_out_valid;
    assign o_source_tag = r_src_tag;
    assign o_channel    = r_channel;
    assign o_level_a    = r_level_a;
    assign o_level_b    = r_level_b;
    assign o_level_c    = r_level_c;
    assign o_level_d    = r_level_d;
    assign o_tail_byte  = r_tail;

endmodule

// File: hdl/level_frame_deframer_core.sv
// Level frame deframer: one received byte per cycle while o_stall is low;
// records out after the checksum byte.
// Throughput: one byte per cycle while o_stall is low; a QUEUE_DEPTH-entry queue decouples the front
// end from the state machine, which stalls only while a record waits to be taken.
// Reset (synchronous, active low): hunt for sync, empty queue, no record, source_id 0.
`include "level_frame_deframer_core_defines.svh"
module level_frame_deframer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // record output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_source_tag,
    output logic [7:0]  o_channel,
    output logic [31:0] o_level_a,
    output logic [31:0] o_level_b,
    output logic [31:0] o_level_c,
    output logic [31:0] o_level_d,
    output logic [7:0]  o_tail_byte,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lfd_pkg::t_qhead     head;
    lfd_pkg::t_back_stat back_stat;
    logic                q_empty;
    logic [7:0]          r_source_id;
    logic                reg_sel_src;

    // Configuration register
    assign pready      = 1'b1;
    assign reg_sel_src = (lfd_pkg::t_reg_idx'(paddr[2]) == lfd_pkg::REG_SOURCE_ID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id <= 8'd0;
        end else if (psel && penable && pwrite && pready && reg_sel_src) begin
            r_source_id <= pwdata[7:0];
        end
    end

    assign prdata = reg_sel_src ? {24'd0, r_source_id} : 32'd0;

    // Front end with byte queue
    lfd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .o_head    (head),
        .i_pop     (back_stat.pop),
        .o_empty   (q_empty)
    );

    // Back end state machine and record register
    lfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_source_id  (r_source_id),
        .o_stat       (back_stat),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_source_tag (o_source_tag),
        .o_channel    (o_channel),
        .o_level_a    (o_level_a),
        .o_level_b    (o_level_b),
        .o_level_c    (o_level_c),
        .o_level_d    (o_level_d),
        .o_tail_byte  (o_tail_byte)
    );

    // Checks
    `LFD_ASSERT_IMPLY(a_pop_not_empty, back_stat.pop, !q_empty)
    `LFD_ASSERT_IMPLY(a_no_overwrite, o_valid && i_stall, !back_stat.emit)
    `LFD_ASSERT_NEXT(a_emit_shows, back_stat.emit, o_valid)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for level_frame_deframer_core: drives byte streams of frames,
// predicts records with its own deframer model, and checks every record field by field.
// Depends on lfd_pkg and the level_frame_deframer_core RTL.
module tb_top;

    // One level record as it leaves the block
    typedef struct packed {
        logic [7:0]  source_tag;
        logic [7:0]  channel;
        logic [31:0] level_a;
        logic [31:0] level_b;
        logic [31:0] level_c;
        logic [31:0] level_d;
        logic [7:0]  tail_byte;
    } t_level_rec;

    // One directed frame: length, verb, payload fill, checksum offset, optional typed record
    typedef struct {
        logic [7:0] len;
        logic [7:0] verb;
        bit         rand_fill;
        logic [7:0] fill;
        logic [7:0] sum_delta;
        bit         typed;
        t_level_rec rec;
    } t_frame_row;

    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_source_tag;
    logic [7:0]  o_channel;
    logic [31:0] o_level_a;
    logic [31:0] o_level_b;
    logic [31:0] o_level_c;
    logic [31:0] o_level_d;
    logic [7:0]  o_tail_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    level_frame_deframer_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_source_tag (o_source_tag),
        .o_channel    (o_channel),
        .o_level_a    (o_level_a),
        .o_level_b    (o_level_b),
        .o_level_c    (o_level_c),
        .o_level_d    (o_level_d),
        .o_tail_byte  (o_tail_byte),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard limit on run time
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Deframer prediction state
    lfd_pkg::t_phase pred_phase = lfd_pkg::PH_HUNT;
    logic [6:0] pred_len = 7'd0;
    logic [6:0] pred_count = 7'd0;
    logic [7:0] pred_sum = 8'd0;
    logic [7:0] pred_payload [lfd_pkg::CAPTURE_BYTES];
    logic [7:0] pred_source_id = 8'd0;

    t_level_rec pending_records [$];
    int         mismatch_count = 0;
    int         bytes_sent = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         pressure_req = 1'b0;
    bit         pressure_done = 1'b0;
    int         hold_left = 0;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic t_level_rec uniform_rec(input logic [7:0] src, input logic [7:0] v);
        t_level_rec r;
        r.source_tag = src;
        r.channel    = v;
        r.level_a    = {4{v}};
        r.level_b    = {4{v}};
        r.level_c    = {4{v}};
        r.level_d    = {4{v}};
        r.tail_byte  = v;
        return r;
    endfunction

    // Back to sync hunt
    task automatic pred_hunt();
        pred_phase = lfd_pkg::PH_HUNT;
        pred_len   = 7'd0;
        pred_count = 7'd0;
    endtask

    // Advance the deframer by one byte; emitted is set when a record comes out
    task automatic deframe_predict(input logic [7:0] b, output bit emitted,
                                   output t_level_rec rec);
        logic [6:0] idx;
        emitted = 1'b0;
        rec = '0;
        case (pred_phase)
            lfd_pkg::PH_HUNT: begin
                if (b == lfd_pkg::SYNC_BYTE)
                    pred_phase = lfd_pkg::PH_LENGTH;
            end
            lfd_pkg::PH_LENGTH: begin
                if (b >= lfd_pkg::LEN_MIN && b <= lfd_pkg::LEN_MAX) begin
                    pred_len   = b[6:0];
                    pred_count = 7'd0;
                    pred_phase = lfd_pkg::PH_VERB;
                end else begin
                    pred_hunt();
                end
            end
            lfd_pkg::PH_VERB: begin
                if (b == lfd_pkg::VERB_LEVELS) begin
                    pred_sum   = b;
                    pred_count = 7'd1;
                    pred_phase = (pred_len == 7'd1) ? lfd_pkg::PH_CHECK : lfd_pkg::PH_DATA;
                end else begin
                    pred_hunt();
                end
            end
            lfd_pkg::PH_DATA: begin
                idx = pred_count - 7'd1;
                if (idx < lfd_pkg::CAPTURE_BYTES)
                    pred_payload[idx] = b;
                pred_sum   = pred_sum + b;
                pred_count = pred_count + 7'd1;
                if (pred_count == pred_len)
                    pred_phase = lfd_pkg::PH_CHECK;
            end
            lfd_pkg::PH_CHECK: begin
                if (pred_sum == b && pred_len >= lfd_pkg::CAPTURE_BYTES + 1) begin
                    rec.source_tag = pred_source_id;
                    rec.channel    = pred_payload[0];
                    rec.level_a    = {pred_payload[1], pred_payload[2],
                                      pred_payload[3], pred_payload[4]};
                    rec.level_b    = {pred_payload[5], pred_payload[6],
                                      pred_payload[7], pred_payload[8]};
                    rec.level_c    = {pred_payload[9], pred_payload[10],
                                      pred_payload[11], pred_payload[12]};
                    rec.level_d    = {pred_payload[13], pred_payload[14],
                                      pred_payload[15], pred_payload[16]};
                    rec.tail_byte  = pred_payload[16];
                    emitted = 1'b1;
                end
                pred_hunt();
            end
            default: pred_hunt();
        endcase
    endtask

    // Offer one byte, wait for it to be taken, then queue what it produces
    task automatic push_byte(input logic [7:0] b, input bit typed, input t_level_rec trec);
        bit         emitted;
        t_level_rec prec;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        deframe_predict(b, emitted, prec);
        if (typed)
            pending_records.push_back(trec);
        else if (emitted)
            pending_records.push_back(prec);
    endtask

    // Sync, length, verb, payload, checksum; stops early where the block drops the frame
    task automatic send_frame(input logic [7:0] len, input logic [7:0] verb,
                              input bit rand_fill, input logic [7:0] fill,
                              input logic [7:0] sum_delta, input bit typed,
                              input t_level_rec trec);
        logic [7:0] sum;
        logic [7:0] pb;
        push_byte(lfd_pkg::SYNC_BYTE, 1'b0, trec);
        push_byte(len, 1'b0, trec);
        if (len < lfd_pkg::LEN_MIN || len > lfd_pkg::LEN_MAX)
            return;
        push_byte(verb, 1'b0, trec);
        if (verb != lfd_pkg::VERB_LEVELS)
            return;
        sum = verb;
        for (int k = 1; k < len; k++) begin
            pb = rand_fill ? 8'($urandom_range(0, 255)) : fill;
            sum = sum + pb;
            push_byte(pb, 1'b0, trec);
        end
        push_byte(sum + sum_delta, typed, trec);
    endtask

    // Random frame mix: mostly good frames, the rest broken frames and line noise
    task automatic send_random_frame();
        int         pick;
        logic [7:0] len;
        logic [7:0] verb;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(18, 127))
                                              : 8'($urandom_range(18, 24));
            send_frame(len, lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0);
        end else if (pick < 78) begin
            send_frame(8'($urandom_range(18, 30)), lfd_pkg::VERB_LEVELS, 1'b1, 8'h00,
                       8'($urandom_range(1, 255)), 1'b0, '0);
        end else if (pick < 84) begin
            send_frame(8'($urandom_range(1, 17)), lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00,
                       1'b0, '0);
        end else if (pick < 89) begin
            verb = 8'($urandom_range(0, 255));
            if (verb == lfd_pkg::VERB_LEVELS)
                verb = 8'h02;
            send_frame(8'($urandom_range(18, 24)), verb, 1'b1, 8'h00, 8'h00, 1'b0, '0);
        end else if (pick < 94) begin
            len = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(128, 255));
            send_frame(len, lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
    endtask

    // One APB transfer; pready is waited for in the access phase, then the bus is left idle
    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let the block go idle, then write source_id and read it back
    task automatic set_source_id(input logic [7:0] v);
        logic [31:0] rd;
        i_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_access(1'b1, 3'(lfd_pkg::REG_SOURCE_ID) << 2, {24'd0, v}, rd);
        pred_source_id = v;
        apb_access(1'b0, 3'(lfd_pkg::REG_SOURCE_ID) << 2, 32'd0, rd);
        if (rd[7:0] !== v)
            report_mismatch($sformatf("source_id read %h want %h", rd[7:0], v));
    endtask

    // Record side: stall pattern, long hold-off on request, and the record check
    always @(posedge i_clk) begin
        t_level_rec got;
        t_level_rec want;
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (pressure_req && !pressure_done) begin
            i_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            pressure_done = 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end

        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_source_tag, o_channel, o_level_a, o_level_b, o_level_c, o_level_d,
                    o_tail_byte};
            if (pending_records.size() == 0) begin
                report_mismatch($sformatf("record with nothing expected: %h", got));
            end else begin
                want = pending_records.pop_front();
                if (got.source_tag !== want.source_tag)
                    report_mismatch($sformatf("source_tag got %h want %h",
                                              got.source_tag, want.source_tag));
                if (got.channel !== want.channel)
                    report_mismatch($sformatf("channel got %h want %h",
                                              got.channel, want.channel));
                if (got.level_a !== want.level_a)
                    report_mismatch($sformatf("level_a got %h want %h",
                                              got.level_a, want.level_a));
                if (got.level_b !== want.level_b)
                    report_mismatch($sformatf("level_b got %h want %h",
                                              got.level_b, want.level_b));
                if (got.level_c !== want.level_c)
                    report_mismatch($sformatf("level_c got %h want %h",
                                              got.level_c, want.level_c));
                if (got.level_d !== want.level_d)
                    report_mismatch($sformatf("level_d got %h want %h",
                                              got.level_d, want.level_d));
                if (got.tail_byte !== want.tail_byte)
                    report_mismatch($sformatf("tail_byte got %h want %h",
                                              got.tail_byte, want.tail_byte));
            end
        end
    end

    // Main sequence
    initial begin
        t_frame_row directed_rows [13];
        logic [7:0] phase_ids [5];
        int         phase_send [5];
        int         phase_recv [5];
        int         target;

        // typed records assume source_id at its reset value of zero
        directed_rows = '{
            '{8'd18,  lfd_pkg::VERB_LEVELS, 1'b0, 8'h00, 8'h00, 1'b1,
              uniform_rec(8'h00, 8'h00)},
            '{8'd127, lfd_pkg::VERB_LEVELS, 1'b0, 8'hFF, 8'h00, 1'b1,
              uniform_rec(8'h00, 8'hFF)},
            // sync value inside the payload carries no meaning
            '{8'd18,  lfd_pkg::VERB_LEVELS, 1'b0, 8'hAA, 8'h00, 1'b1,
              uniform_rec(8'h00, 8'hAA)},
            // bad lengths
            '{8'd0,   lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0},
            '{8'd128, lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0},
            '{8'd255, lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0},
            // bad verbs
            '{8'd18,  8'h00,                1'b1, 8'h00, 8'h00, 1'b0, '0},
            '{8'd18,  8'hFF,                1'b1, 8'h00, 8'h00, 1'b0, '0},
            // short payloads with a good checksum give nothing
            '{8'd17,  lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0},
            '{8'd1,   lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0},
            // checksum off by one
            '{8'd18,  lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h01, 1'b0, '0},
            // long payload, tail bytes only in the sum
            '{8'd40,  lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0},
            '{8'd127, lfd_pkg::VERB_LEVELS, 1'b1, 8'h00, 8'h00, 1'b0, '0}
        };
        phase_ids  = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'h5A};
        phase_send = '{0, 73, 0, 19, 0};
        phase_recv = '{0, 0, 73, 19, 0};

        // hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise while hunting, then the directed frames
        push_byte(8'h00, 1'b0, '0);
        push_byte(8'hFF, 1'b0, '0);
        push_byte(8'h55, 1'b0, '0);
        foreach (directed_rows[r])
            send_frame(directed_rows[r].len, directed_rows[r].verb,
                       directed_rows[r].rand_fill, directed_rows[r].fill,
                       directed_rows[r].sum_delta, directed_rows[r].typed,
                       directed_rows[r].rec);

        // random phases with different idle patterns; the last one holds off the receiver
        for (int p = 0; p < 5; p++) begin
            set_source_id(phase_ids[p]);
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            if (p == 4)
                pressure_req = 1'b1;
            target = bytes_sent + 180;
            while (bytes_sent < target)
                send_random_frame();
        end

        // drain
        i_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lfd_pkg.sv
hdl/lfd_front.sv
hdl/lfd_back.sv
hdl/level_frame_deframer_core.sv
tb/tb_top.sv
